>>> hdl/aacd_pkg.sv
// ----------------------------------------------------------------------------
// aacd_pkg
// Shared types, constants and helpers of the addressed ascii command decoder.
// ----------------------------------------------------------------------------
package aacd_pkg;

    localparam int LINE_BYTES = 32;
    localparam int COUNT_W    = $clog2(LINE_BYTES);
    localparam int N_W        = COUNT_W + 1;
    localparam int KEEP_BYTES = 19;
    localparam int ADDR_CHARS = 6;
    localparam int CAL_WORDS  = 3;

    localparam logic [7:0] CR_BYTE    = 8'h0d;
    localparam logic [7:0] CH_STAR    = 8'h2a;
    localparam logic [7:0] CH_EQUAL   = 8'h3d;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_A       = 8'h41;
    localparam logic [7:0] CH_B       = 8'h42;
    localparam logic [7:0] CH_C       = 8'h43;
    localparam logic [7:0] CH_D       = 8'h44;
    localparam logic [7:0] CH_E       = 8'h45;
    localparam logic [7:0] CH_F       = 8'h46;
    localparam logic [7:0] CH_R       = 8'h52;
    localparam logic [7:0] CH_S       = 8'h53;
    localparam logic [7:0] CH_W       = 8'h57;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;

    localparam logic [N_W-1:0] LEN_SHORT = N_W'(10);
    localparam logic [N_W-1:0] LEN_RC    = N_W'(11);
    localparam logic [N_W-1:0] LEN_SA    = N_W'(17);
    localparam logic [N_W-1:0] LEN_SC    = N_W'(20);

    typedef enum logic [2:0] {
        KIND_RD = 3'd0,
        KIND_RC = 3'd1,
        KIND_SC = 3'd2,
        KIND_RE = 3'd3,
        KIND_WE = 3'd4,
        KIND_SA = 3'd5
    } kind_t;

    localparam logic [1:0] SEL_A = 2'd0;
    localparam logic [1:0] SEL_B = 2'd1;
    localparam logic [1:0] SEL_C = 2'd2;

    typedef logic [KEEP_BYTES-1:0][7:0] line_t;
    typedef logic [ADDR_CHARS-1:0][7:0] addr_t;
    typedef logic [CAL_WORDS-1:0][31:0] cal_set_t;

    localparam addr_t ADDR_RESET = '{8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h31};
    localparam cal_set_t CAL_RESET = '{32'h0000_0000, 32'h0000_803F, 32'h0000_0000};

    typedef struct packed {
        logic        emit;
        kind_t       kind;
        logic [1:0]  sel;
        logic [31:0] value;
        logic        wa_next;
        logic        cal_we;
        logic        addr_we;
    } dec_t;

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9)
            v = 4'(c - CH_DIGIT_0);
        else if (c >= CH_A && c <= CH_F)
            v = 4'(c - CH_A + 8'd10);
        else if (c >= CH_LOWER_A && c <= CH_LOWER_F)
            v = 4'(c - CH_LOWER_A + 8'd10);
        return v;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
    endfunction

endpackage

>>> hdl/aacd_decode.sv
// ----------------------------------------------------------------------------
// aacd_decode
// Decodes one finished line: address match, command match, length rule and
// write-enable rule; gives the result item and the state updates.
// ----------------------------------------------------------------------------
module aacd_decode (
    input  logic                  line_end,
    input  aacd_pkg::line_t       line,
    input  logic [aacd_pkg::N_W-1:0] n,
    input  logic                  write_allowed,
    input  aacd_pkg::addr_t       addr,
    input  aacd_pkg::cal_set_t    cal,
    output aacd_pkg::dec_t        dec
);
    import aacd_pkg::*;

    logic        addr_ok;
    logic        sel_ok;
    logic [1:0]  sel;
    logic        digits_ok;
    logic [31:0] hex_word;
    logic [7:0]  c7;
    logic [7:0]  c8;
    logic [7:0]  c9;

    assign c7 = line[7];
    assign c8 = line[8];
    assign c9 = line[9];

    always_comb
    begin
        addr_ok = (line[0] == CH_STAR);
        for (int i = 0; i < ADDR_CHARS; i++)
            if (line[1 + i] != addr[i])
                addr_ok = 1'b0;
        digits_ok = 1'b1;
        for (int i = 0; i < ADDR_CHARS; i++)
            if (!is_digit(line[10 + i]))
                digits_ok = 1'b0;
        for (int i = 0; i < 8; i++)
            hex_word[31 - 4*i -: 4] = hex_nibble(line[11 + i]);
    end

    always_comb
    begin
        sel_ok = 1'b1;
        case (c9)
            CH_A:    sel = SEL_A;
            CH_B:    sel = SEL_B;
            CH_C:    sel = SEL_C;
            default:
            begin
                sel    = SEL_A;
                sel_ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        dec         = '0;
        dec.kind    = KIND_RD;
        dec.wa_next = write_allowed;
        if (line_end && addr_ok)
        begin
            if (c7 == CH_R && c8 == CH_D && n == LEN_SHORT)
            begin
                dec.emit    = 1'b1;
                dec.wa_next = 1'b0;
            end
            else if (c7 == CH_R && c8 == CH_C && sel_ok && n == LEN_RC)
            begin
                dec.emit    = 1'b1;
                dec.kind    = KIND_RC;
                dec.sel     = sel;
                dec.value   = cal[sel];
                dec.wa_next = 1'b0;
            end
            else if (c7 == CH_S && c8 == CH_C && sel_ok && line[10] == CH_EQUAL
                     && n == LEN_SC && write_allowed)
            begin
                dec.emit    = 1'b1;
                dec.kind    = KIND_SC;
                dec.sel     = sel;
                dec.value   = hex_word;
                dec.wa_next = 1'b0;
                dec.cal_we  = 1'b1;
            end
            else if (c7 == CH_R && c8 == CH_E && n == LEN_SHORT)
            begin
                dec.emit    = 1'b1;
                dec.kind    = KIND_RE;
                dec.wa_next = 1'b0;
            end
            else if (c7 == CH_W && c8 == CH_E && n == LEN_SHORT)
            begin
                dec.emit    = 1'b1;
                dec.kind    = KIND_WE;
                dec.wa_next = 1'b1;
            end
            else if (c7 == CH_S && c8 == CH_A && c9 == CH_EQUAL && n == LEN_SA
                     && write_allowed)
            begin
                dec.wa_next = 1'b0;
                if (digits_ok)
                begin
                    dec.emit    = 1'b1;
                    dec.kind    = KIND_SA;
                    dec.addr_we = 1'b1;
                end
            end
        end
    end

endmodule

>>> hdl/ascii_addressed_command_decoder_unit.sv
// ----------------------------------------------------------------------------
// ascii_addressed_command_decoder_unit
// Collects received bytes into a line and decodes one addressed command per
// carriage return; keeps the address and three calibration words.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid / in_stall    | rx_byte
//  out     | output    | out_valid / out_stall  | command_kind, cal_select, cal_value
//
//  one item per cycle while the output is not stalled; a result passes through
//  the input register and the result register around the decode logic.
//  reset clears the line count, the write-enable flag, and restores the
//  address and calibration words; no clearing pass.
//  a stalled result holds; one more byte waits in the input register, then
//  in_stall rises.
// ----------------------------------------------------------------------------
module ascii_addressed_command_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  command_kind,
    output logic [1:0]  cal_select,
    output logic [31:0] cal_value
);
    import aacd_pkg::*;

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic [COUNT_W-1:0] count_reg;
    line_t              line_reg;
    logic               wa_reg;
    addr_t              addr_reg;
    cal_set_t           cal_reg;
    logic               out_valid_reg;
    logic [2:0]         kind_reg;
    logic [1:0]         sel_reg;
    logic [31:0]        value_reg;

    logic               advance;
    logic [N_W-1:0]     n_next;
    logic               full;
    logic               is_cr;
    dec_t               dec;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign n_next   = N_W'(count_reg) + N_W'(1);
    assign full     = (n_next >= N_W'(LINE_BYTES));
    assign is_cr    = (in_byte_reg == CR_BYTE);

    aacd_decode u_decode (
        .line_end      (advance && is_cr && !full),
        .line          (line_reg),
        .n             (n_next),
        .write_allowed (wa_reg),
        .addr          (addr_reg),
        .cal           (cal_reg),
        .dec           (dec)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            count_reg     <= '0;
            wa_reg        <= 1'b0;
            addr_reg      <= ADDR_RESET;
            cal_reg       <= CAL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
            begin
                if (full || is_cr)
                    count_reg <= '0;
                else
                    count_reg <= n_next[COUNT_W-1:0];
                wa_reg <= dec.wa_next;
                if (dec.addr_we)
                    for (int i = 0; i < ADDR_CHARS; i++)
                        addr_reg[i] <= line_reg[10 + i];
                if (dec.cal_we)
                    cal_reg[dec.sel] <= dec.value;
            end

            if (advance && dec.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_byte_reg <= rx_byte;
        if (advance)
            for (int i = 0; i < KEEP_BYTES; i++)
                if (count_reg == COUNT_W'(i))
                    line_reg[i] <= in_byte_reg;
        if (advance && dec.emit)
        begin
            kind_reg  <= dec.kind;
            sel_reg   <= dec.sel;
            value_reg <= dec.value;
        end
    end

    assign out_valid    = out_valid_reg;
    assign command_kind = kind_reg;
    assign cal_select   = sel_reg;
    assign cal_value    = value_reg;

endmodule
